[hw/rtl/multi_channel_alarm_timer_unit_macros.svh]
// ----------------------------------------------------------------------------
// multi channel alarm timer unit assertion macros
// shared property templates for the concurrent checks of the timer block
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_ALARM_TIMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_ALARM_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define MCAT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mcat_pkg.sv]
// ----------------------------------------------------------------------------
// mcat_pkg
// types, codes and sizes shared by the alarm timer modules
// ----------------------------------------------------------------------------
package mcat_pkg;

   localparam int NUM_ALARMS = 8;
   localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

   localparam logic [15:0] HALF_RANGE = 16'h8000;

   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_SET_REL   = 3'd1;
   localparam logic [2:0] ACT_SET_ABS   = 3'd2;
   localparam logic [2:0] ACT_CANCEL    = 3'd3;
   localparam logic [2:0] ACT_READ_REM  = 3'd4;
   localparam logic [2:0] ACT_READ_CNT  = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ID     = 3'd1;
   localparam logic [2:0] ST_BAD_VALUE  = 3'd2;
   localparam logic [2:0] ST_ACTIVE     = 3'd3;
   localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;

   localparam logic KIND_EXPIRY   = 1'b0;
   localparam logic KIND_RESPONSE = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  alarm_index;
      logic [15:0] amount;
      logic [15:0] period;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  alarm_number;
      logic [2:0]  status;
      logic [15:0] value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
      logic        sub;
   } alu_op_type;

endpackage

[hw/rtl/mcat_ram.sv]
// ----------------------------------------------------------------------------
// mcat_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mcat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mcat_alu.sv]
// ----------------------------------------------------------------------------
// mcat_alu
// shared 16-bit wrapping add / subtract unit
// ----------------------------------------------------------------------------
module mcat_alu (
   input  mcat_pkg::alu_op_type op,
   output logic [15:0]          sum
);

   logic [15:0] b_eff;

   assign b_eff = op.sub ? ~op.b : op.b;
   assign sum   = 16'(op.a + b_eff + {15'd0, op.sub});

endmodule

[hw/rtl/multi_channel_alarm_timer_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_alarm_timer_unit
// 16-bit wrapping tick counter with a bank of alarms, swept on each tick
// ----------------------------------------------------------------------------
// channel   ports                              handshake
// request   start, busy, req_data              taken when start and not busy
// response  rsp_valid, rsp_data                one-cycle strobe, no back-pressure
// csr       csr_wr_en, csr_wr_data             max_offset written when enabled
//
// a tick sweeps the alarms in turn, each with a read, a compare, and an add step
// for each periodic alarm that fires, all on the one shared adder
// set, cancel, read counter and rejected commands answer from S_DEC, a good read remaining from S_RR
// reset clears the counter, active and waypoint bits; max_offset resets to 65535
// results leave through an output register; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "multi_channel_alarm_timer_unit_macros.svh"

module multi_channel_alarm_timer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mcat_pkg::req_type req_data,
   output logic              rsp_valid,
   output mcat_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_DEC, S_RR, S_T_RD, S_T_CMP, S_T_UPD, S_T_END
   } state_type;

   state_type                               state_ff, state_in;
   mcat_pkg::req_type                       req_ff, req_in;
   logic [15:0]                             count_ff, count_in;
   logic [15:0]                             max_off_ff, max_off_in;
   logic [mcat_pkg::IDX_W-1:0]              sweep_ff, sweep_in;
   logic [mcat_pkg::IDX_W-1:0]              pend_ff, pend_in;
   logic                                    pend_vld_ff, pend_vld_in;
   logic [mcat_pkg::NUM_ALARMS-1:0]         active_ff, active_in;
   logic [mcat_pkg::NUM_ALARMS-1:0]         wp_ff, wp_in;
   mcat_pkg::rsp_type                       rsp_ff, rsp_in;
   logic                                    rsp_vld_ff, rsp_vld_in;

   mcat_pkg::alu_op_type                    alu_op;
   logic [15:0]                             alu_sum;
   logic [mcat_pkg::IDX_W-1:0]              ram_addr;
   logic                                    exp_we;
   logic [15:0]                             exp_wd;
   logic [15:0]                             exp_rd;
   logic                                    per_we;
   logic [15:0]                             per_rd;
   logic [mcat_pkg::IDX_W-1:0]              idx_lo;
   logic                                    idx_ok;
   logic                                    next_alarm;
   logic                                    rel_bad;
   logic                                    abs_bad;

   mcat_ram #(.WIDTH(16), .DEPTH(mcat_pkg::NUM_ALARMS)) u_expiry_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (ram_addr),
      .wr_data (exp_wd),
      .rd_addr (ram_addr),
      .rd_data (exp_rd)
   );

   mcat_ram #(.WIDTH(16), .DEPTH(mcat_pkg::NUM_ALARMS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (ram_addr),
      .wr_data (req_ff.period),
      .rd_addr (ram_addr),
      .rd_data (per_rd)
   );

   mcat_alu u_alu (
      .op  (alu_op),
      .sum (alu_sum)
   );

   assign idx_lo  = req_ff.alarm_index[mcat_pkg::IDX_W-1:0];
   assign idx_ok  = (req_ff.alarm_index < 8'(mcat_pkg::NUM_ALARMS));
   assign rel_bad = (req_ff.amount == 16'd0) || (req_ff.amount > max_off_ff)
                    || (req_ff.period > max_off_ff);
   assign abs_bad = (req_ff.period > max_off_ff);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      count_in    = count_ff;
      max_off_in  = csr_wr_en ? csr_wr_data : max_off_ff;
      sweep_in    = sweep_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      active_in   = active_ff;
      wp_in       = wp_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      alu_op      = '0;
      ram_addr    = idx_lo;
      exp_we      = 1'b0;
      exp_wd      = alu_sum;
      per_we      = 1'b0;
      next_alarm  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.action == mcat_pkg::ACT_TICK) begin
                  count_in    = 16'(count_ff + 16'd1);
                  sweep_in    = '0;
                  pend_vld_in = 1'b0;
                  state_in    = S_T_RD;
               end else begin
                  state_in = S_DEC;
               end
            end
         end

         S_DEC: begin
            state_in            = S_IDLE;
            rsp_in.kind         = mcat_pkg::KIND_RESPONSE;
            rsp_in.alarm_number = req_ff.alarm_index;
            rsp_in.status       = mcat_pkg::ST_OK;
            rsp_in.value        = '0;
            rsp_in.last         = 1'b1;
            rsp_vld_in          = 1'b1;
            if (req_ff.action == mcat_pkg::ACT_READ_CNT) begin
               rsp_in.value = count_ff;
            end else if (req_ff.action > mcat_pkg::ACT_READ_CNT) begin
               rsp_vld_in = 1'b0;
            end else if (!idx_ok) begin
               rsp_in.status = mcat_pkg::ST_BAD_ID;
            end else begin
               unique case (req_ff.action)
                  mcat_pkg::ACT_SET_REL: begin
                     alu_op = '{a: count_ff, b: req_ff.amount, sub: 1'b0};
                     if (rel_bad) begin
                        rsp_in.status = mcat_pkg::ST_BAD_VALUE;
                     end else if (active_ff[idx_lo]) begin
                        rsp_in.status = mcat_pkg::ST_ACTIVE;
                     end else begin
                        exp_we            = 1'b1;
                        exp_wd            = alu_sum;
                        per_we            = 1'b1;
                        active_in[idx_lo] = 1'b1;
                        wp_in[idx_lo]     = 1'b0;
                     end
                  end
                  mcat_pkg::ACT_SET_ABS: begin
                     alu_op = '{a: count_ff, b: req_ff.amount, sub: 1'b1};
                     if (abs_bad) begin
                        rsp_in.status = mcat_pkg::ST_BAD_VALUE;
                     end else if (active_ff[idx_lo]) begin
                        rsp_in.status = mcat_pkg::ST_ACTIVE;
                     end else begin
                        exp_we            = 1'b1;
                        per_we            = 1'b1;
                        active_in[idx_lo] = 1'b1;
                        wp_in[idx_lo]     = !alu_sum[15];
                        exp_wd            = alu_sum[15] ? req_ff.amount
                                                        : (req_ff.amount ^ mcat_pkg::HALF_RANGE);
                     end
                  end
                  mcat_pkg::ACT_CANCEL: begin
                     if (!active_ff[idx_lo]) begin
                        rsp_in.status = mcat_pkg::ST_NOT_ACTIVE;
                     end else begin
                        active_in[idx_lo] = 1'b0;
                        wp_in[idx_lo]     = 1'b0;
                     end
                  end
                  default: begin
                     if (!active_ff[idx_lo]) begin
                        rsp_in.status = mcat_pkg::ST_NOT_ACTIVE;
                     end else begin
                        rsp_vld_in = 1'b0;
                        state_in   = S_RR;
                     end
                  end
               endcase
            end
         end

         S_RR: begin
            alu_op              = '{a: exp_rd, b: count_ff, sub: 1'b1};
            rsp_in.kind         = mcat_pkg::KIND_RESPONSE;
            rsp_in.alarm_number = req_ff.alarm_index;
            rsp_in.status       = mcat_pkg::ST_OK;
            rsp_in.value        = alu_sum ^ (wp_ff[idx_lo] ? mcat_pkg::HALF_RANGE : 16'd0);
            rsp_in.last         = 1'b1;
            rsp_vld_in          = 1'b1;
            state_in            = S_IDLE;
         end

         S_T_RD: begin
            ram_addr = sweep_ff;
            state_in = S_T_CMP;
         end

         S_T_CMP: begin
            ram_addr = sweep_ff;
            alu_op   = '{a: count_ff, b: exp_rd, sub: 1'b1};
            if (active_ff[sweep_ff] && !alu_sum[15]) begin
               if (wp_ff[sweep_ff]) begin
                  exp_we          = 1'b1;
                  exp_wd          = exp_rd ^ mcat_pkg::HALF_RANGE;
                  wp_in[sweep_ff] = 1'b0;
                  next_alarm      = 1'b1;
               end else begin
                  if (pend_vld_ff) begin
                     rsp_in.kind         = mcat_pkg::KIND_EXPIRY;
                     rsp_in.alarm_number = 8'(pend_ff);
                     rsp_in.status       = mcat_pkg::ST_OK;
                     rsp_in.value        = '0;
                     rsp_in.last         = 1'b0;
                     rsp_vld_in          = 1'b1;
                  end
                  pend_in     = sweep_ff;
                  pend_vld_in = 1'b1;
                  if (per_rd != 16'd0) begin
                     state_in = S_T_UPD;
                  end else begin
                     active_in[sweep_ff] = 1'b0;
                     next_alarm          = 1'b1;
                  end
               end
            end else begin
               next_alarm = 1'b1;
            end
         end

         S_T_UPD: begin
            ram_addr   = sweep_ff;
            alu_op     = '{a: exp_rd, b: per_rd, sub: 1'b0};
            exp_we     = 1'b1;
            exp_wd     = alu_sum;
            next_alarm = 1'b1;
         end

         S_T_END: begin
            if (pend_vld_ff) begin
               rsp_in.kind         = mcat_pkg::KIND_EXPIRY;
               rsp_in.alarm_number = 8'(pend_ff);
               rsp_in.status       = mcat_pkg::ST_OK;
               rsp_in.value        = '0;
               rsp_in.last         = 1'b1;
               rsp_vld_in          = 1'b1;
            end
            pend_vld_in = 1'b0;
            state_in    = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (next_alarm) begin
         if (sweep_ff == mcat_pkg::IDX_W'(mcat_pkg::NUM_ALARMS - 1)) begin
            state_in = S_T_END;
         end else begin
            sweep_in = sweep_ff + 1'b1;
            state_in = S_T_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         max_off_ff  <= 16'hFFFF;
         pend_vld_ff <= 1'b0;
         active_ff   <= '0;
         wp_ff       <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         max_off_ff  <= max_off_in;
         pend_vld_ff <= pend_vld_in;
         active_ff   <= active_in;
         wp_ff       <= wp_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      req_ff   <= req_in;
      sweep_ff <= sweep_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `MCAT_ASSERT_NEXT(a_tick_advances, clock, reset,
      start && !busy && (req_data.action == mcat_pkg::ACT_TICK),
      count_ff == 16'($past(count_ff) + 16'd1), "tick did not advance the counter")

   `MCAT_ASSERT_SAME(a_expiry_clean, clock, reset,
      rsp_vld_ff && (rsp_ff.kind == mcat_pkg::KIND_EXPIRY),
      (rsp_ff.status == mcat_pkg::ST_OK) && (rsp_ff.value == 16'd0), "expiry word not clean")

   `MCAT_ASSERT_SAME(a_response_last, clock, reset,
      rsp_vld_ff && (rsp_ff.kind == mcat_pkg::KIND_RESPONSE),
      rsp_ff.last, "command response not marked last")

   `MCAT_ASSERT_NEXT(a_waypoint_needs_active, clock, reset,
      1'b1, (wp_ff & ~active_ff) == '0, "waypoint set on inactive alarm")

endmodule
